[rtl/core/dht_pkg.sv]
package dht_pkg;

	localparam int HANDLE_W = 32;
	localparam int SLOT_W   = 10;

	localparam logic [1:0] KIND_ADD    = 2'd0;
	localparam logic [1:0] KIND_REMOVE = 2'd1;
	localparam logic [1:0] KIND_LOOKUP = 2'd2;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_FULL    = 2'd1;
	localparam logic [1:0] ST_UNKNOWN = 2'd2;

	typedef struct packed {
		logic [1:0]          kind;
		logic [HANDLE_W-1:0] handle;
	} dht_req_t;

	typedef struct packed {
		logic [1:0]          status;
		logic [SLOT_W-1:0]   slot;
		logic [HANDLE_W-1:0] new_handle;
		logic                moved;
		logic [SLOT_W-1:0]   moved_from;
		logic [HANDLE_W-1:0] moved_handle;
	} dht_rsp_t;

	typedef enum logic [2:0] {
		EM_NONE    = 3'd0,
		EM_ADD     = 3'd1,
		EM_FULL    = 3'd2,
		EM_UNKNOWN = 3'd3,
		EM_FOUND   = 3'd4,
		EM_DROP    = 3'd5,
		EM_MOVE    = 3'd6
	} dht_emit_t;

	typedef struct packed {
		logic      capture;
		logic      scan;
		logic      rd_last;
		dht_emit_t emit;
	} dht_cmd_t;

	typedef struct packed {
		logic [1:0] kind;
		logic       full;
		logic       scan_done;
		logic       scan_hit;
		logic       hit;
		logic       last_hit;
		logic       out_free;
	} dht_stat_t;

endpackage

[rtl/core/dht_ctrl.sv]
module dht_ctrl
	import dht_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  dht_stat_t stat,
	output dht_cmd_t  cmd
);

	typedef enum logic [5:0] {
		S_IDLE    = 6'b000001,
		S_ADD     = 6'b000010,
		S_SCAN    = 6'b000100,
		S_RD_LAST = 6'b001000,
		S_MOVE    = 6'b010000,
		S_REPLY   = 6'b100000
	} state_t;

	state_t state_q, state_d;

	assign req_stall = (state_q != S_IDLE);

	always_comb begin
		state_d     = state_q;
		cmd.capture = 1'b0;
		cmd.scan    = 1'b0;
		cmd.rd_last = 1'b0;
		cmd.emit    = EM_NONE;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_SCAN;
				end
			end
			S_ADD: begin
				if (stat.out_free) begin
					cmd.emit = stat.full ? EM_FULL : EM_ADD;
					state_d  = S_IDLE;
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (stat.scan_done) begin
					if (stat.scan_hit && stat.kind == KIND_REMOVE) begin
						state_d = S_RD_LAST;
					end else begin
						state_d = S_REPLY;
					end
				end
			end
			S_RD_LAST: begin
				cmd.rd_last = 1'b1;
				state_d     = stat.last_hit ? S_REPLY : S_MOVE;
			end
			S_MOVE: begin
				if (stat.out_free) begin
					cmd.emit = EM_MOVE;
					state_d  = S_IDLE;
				end
			end
			S_REPLY: begin
				if (stat.out_free) begin
					if (!stat.hit) begin
						cmd.emit = EM_UNKNOWN;
					end else if (stat.kind == KIND_REMOVE) begin
						cmd.emit = EM_DROP;
					end else begin
						cmd.emit = EM_FOUND;
					end
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		// route the new item by kind right at capture
		if (state_q == S_IDLE && req_valid) begin
			priority if (stat.kind == KIND_ADD) begin
				state_d = S_ADD;
			end else if (stat.kind == KIND_REMOVE || stat.kind == KIND_LOOKUP) begin
				state_d = S_SCAN;
			end else begin
				state_d = S_REPLY;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[rtl/core/dht_dpath.sv]
module dht_dpath
	import dht_pkg::*;
#(
	parameter int CAPACITY = 1024
) (
	input  logic      clk,
	input  logic      arst_n,
	input  dht_req_t  req,
	input  dht_cmd_t  cmd,
	output dht_stat_t stat,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output dht_rsp_t  rsp
);

	localparam int IW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	logic [HANDLE_W-1:0] slot_mem [CAPACITY];

	logic [1:0]          kind_q;
	logic [HANDLE_W-1:0] handle_q;
	logic [CW-1:0]       count_q;
	logic [HANDLE_W-1:0] next_q;
	logic [CW-1:0]       ptr_q;
	logic                rvalid_s1;
	logic [IW-1:0]       raddr_s1;
	logic [HANDLE_W-1:0] rdata_q;
	logic                hit_q;
	logic [IW-1:0]       pos_q;
	logic                rsp_valid_q;
	dht_rsp_t            rsp_q;
	dht_rsp_t            rsp_d;

	logic          more;
	logic          hit_now;
	logic          scan_issue;
	logic          rd_en;
	logic [IW-1:0] rd_addr;
	logic          wr_en;
	logic [IW-1:0] wr_addr;
	logic [HANDLE_W-1:0] wr_data;
	logic [CW-1:0] last_cnt;
	logic [IW-1:0] last_idx;
	logic          out_free;

	assign more       = (ptr_q < count_q);
	assign hit_now    = rvalid_s1 && (rdata_q == handle_q);
	assign scan_issue = cmd.scan && more && !hit_now;
	assign last_cnt   = count_q - CW'(1);
	assign last_idx   = last_cnt[IW-1:0];
	assign out_free   = !rsp_valid_q || !rsp_stall;

	// kind comes straight from the port while the item is being captured
	assign stat.kind      = cmd.capture ? req.kind : kind_q;
	assign stat.full      = (count_q == CW'(CAPACITY));
	assign stat.scan_done = hit_now || (!rvalid_s1 && !more);
	assign stat.scan_hit  = hit_now;
	assign stat.hit       = hit_q;
	assign stat.last_hit  = (pos_q == last_idx);
	assign stat.out_free  = out_free;

	assign rd_en   = scan_issue || cmd.rd_last;
	assign rd_addr = cmd.rd_last ? last_idx : ptr_q[IW-1:0];
	assign wr_en   = (cmd.emit == EM_ADD) || (cmd.emit == EM_MOVE);
	assign wr_addr = (cmd.emit == EM_ADD) ? count_q[IW-1:0] : pos_q;
	assign wr_data = (cmd.emit == EM_ADD) ? next_q : rdata_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= slot_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q   <= req.kind;
			handle_q <= req.handle;
		end
		raddr_s1 <= ptr_q[IW-1:0];
		if (cmd.scan && hit_now) begin
			pos_q <= raddr_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			next_q    <= HANDLE_W'(1);
			ptr_q     <= '0;
			rvalid_s1 <= 1'b0;
			hit_q     <= 1'b0;
		end else begin
			rvalid_s1 <= scan_issue;
			if (cmd.capture) begin
				ptr_q <= '0;
				hit_q <= 1'b0;
			end else if (scan_issue) begin
				ptr_q <= ptr_q + CW'(1);
			end
			if (cmd.scan && hit_now) begin
				hit_q <= 1'b1;
			end
			if (cmd.emit == EM_ADD) begin
				count_q <= count_q + CW'(1);
				next_q  <= next_q + HANDLE_W'(1);
			end else if (cmd.emit == EM_DROP || cmd.emit == EM_MOVE) begin
				count_q <= last_cnt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.emit != EM_NONE) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_comb begin
		rsp_d = '0;
		unique case (cmd.emit)
			EM_ADD: begin
				rsp_d.status     = ST_OK;
				rsp_d.slot       = SLOT_W'(count_q[IW-1:0]);
				rsp_d.new_handle = next_q;
			end
			EM_FULL: begin
				rsp_d.status = ST_FULL;
			end
			EM_FOUND, EM_DROP: begin
				rsp_d.status = ST_OK;
				rsp_d.slot   = SLOT_W'(pos_q);
			end
			EM_MOVE: begin
				rsp_d.status       = ST_OK;
				rsp_d.slot         = SLOT_W'(pos_q);
				rsp_d.moved        = 1'b1;
				rsp_d.moved_from   = SLOT_W'(last_idx);
				rsp_d.moved_handle = rdata_q;
			end
			default: begin
				rsp_d.status = ST_UNKNOWN;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.emit != EM_NONE) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

[rtl/core/dense_handle_table_unit.sv]
// Dense handle table: live ids stay packed in slots 0..count-1 of a CAPACITY-deep
// single-port-read memory. Add issues the next id (starts at 1, wraps at 2^32) into
// the slot at the end, or answers full when every slot is live. Remove and look-up
// scan the live slots one memory read per cycle from slot 0 and stop at the lowest
// match. A remove that finds its id then reads the last slot; if the match is not
// in the last slot it copies that entry over the freed one and reports the move so
// the owner can move its payload. An undefined kind answers unknown with no scan.
// A stalled output holds the block in its answering state while the output
// register is still held. One item is in work at a time; a finished result sits
// in the output register while the next item is taken. No clearing pass is run
// after reset: only written slots are ever read.
module dense_handle_table_unit
	import dht_pkg::*;
#(
	parameter int CAPACITY = 1024
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_stall,
	input  dht_req_t req,
	output logic     rsp_valid,
	input  logic     rsp_stall,
	output dht_rsp_t rsp
);

	dht_cmd_t  cmd;
	dht_stat_t stat;

	dht_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	dht_dpath #(
		.CAPACITY (CAPACITY)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.stat      (stat),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit != EM_NONE |-> stat.out_free)
		else $error("result loaded while output register is held");

	a_add_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit == EM_ADD |-> !stat.full)
		else $error("add placed into a full table");

	a_move_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit == EM_MOVE |-> !stat.last_hit && stat.hit)
		else $error("move issued for entry already in last slot");

	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> req_stall)
		else $error("new item taken while previous one is in work");

endmodule

[test/dense_handle_table_unit_tb.sv]
module dense_handle_table_unit_tb
	import dht_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CAPACITY = 1024;
	// kind 3 is not a defined operation; the block must answer it as unknown
	localparam logic [1:0] KIND_UNDEF = 2'd3;

	class dht_scoreboard;
		logic [HANDLE_W-1:0] ids [CAPACITY];
		int unsigned         count;
		logic [HANDLE_W-1:0] next_id;
		dht_rsp_t            expected_q [$];
		int                  errors;

		function new();
			count   = 0;
			next_id = 1;
			errors  = 0;
		endfunction

		// lowest live slot holding the id
		function bit locate(logic [HANDLE_W-1:0] h, output int unsigned pos);
			pos = 0;
			for (int unsigned i = 0; i < count; i++) begin
				if (ids[i] == h) begin
					pos = i;
					return 1'b1;
				end
			end
			return 1'b0;
		endfunction

		function void note_request(dht_req_t r);
			dht_rsp_t    want;
			int unsigned pos;
			int unsigned last;
			want        = '0;
			want.status = ST_UNKNOWN;
			case (r.kind)
				KIND_ADD: begin
					if (count >= CAPACITY) begin
						want.status = ST_FULL;
					end else begin
						want.status     = ST_OK;
						want.new_handle = next_id;
						want.slot       = count[SLOT_W-1:0];
						ids[count]      = next_id;
						next_id         = next_id + 1'b1;
						count++;
					end
				end
				KIND_REMOVE: begin
					if (locate(r.handle, pos)) begin
						last        = count - 1;
						want.status = ST_OK;
						want.slot   = pos[SLOT_W-1:0];
						// swap-remove: last entry fills the hole
						if (last != pos) begin
							want.moved        = 1'b1;
							want.moved_from   = last[SLOT_W-1:0];
							want.moved_handle = ids[last];
							ids[pos]          = ids[last];
						end
						count = last;
					end
				end
				KIND_LOOKUP: begin
					if (locate(r.handle, pos)) begin
						want.status = ST_OK;
						want.slot   = pos[SLOT_W-1:0];
					end
				end
				default: ;
			endcase
			expected_q.push_back(want);
		endfunction

		function void check_field(string name, logic [HANDLE_W-1:0] want,
				logic [HANDLE_W-1:0] got);
			if (got !== want) begin
				$error("%s: expected %0h, got %0h", name, want, got);
				errors++;
			end
		endfunction

		function void check_response(dht_rsp_t got);
			dht_rsp_t want;
			if (expected_q.size() == 0) begin
				$error("result with no request waiting: %p", got);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			check_field("status", want.status, got.status);
			check_field("slot", want.slot, got.slot);
			check_field("new_handle", want.new_handle, got.new_handle);
			check_field("moved", want.moved, got.moved);
			check_field("moved_from", want.moved_from, got.moved_from);
			check_field("moved_handle", want.moved_handle, got.moved_handle);
		endfunction
	endclass

	logic     clk = 1'b0;
	logic     arst_n;
	logic     req_valid;
	logic     req_stall;
	dht_req_t req;
	logic     rsp_valid;
	logic     rsp_stall = 1'b0;
	dht_rsp_t rsp;

	int            src_idle_pct;
	int            snk_stall_pct;
	dht_scoreboard sb;

	always #5 clk = ~clk;

	dense_handle_table_unit #(
		.CAPACITY(CAPACITY)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	always @(negedge clk) begin
		rsp_stall <= ($urandom_range(99) < snk_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			sb.check_response(rsp);
	end

	task automatic set_pace(input int phase);
		case (phase % 4)
			0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
			1: begin src_idle_pct = 47; snk_stall_pct = 0;  end
			2: begin src_idle_pct = 0;  snk_stall_pct = 47; end
			default: begin src_idle_pct = 29; snk_stall_pct = 29; end
		endcase
	endtask

	task automatic send_item(input logic [1:0] kind, input logic [HANDLE_W-1:0] handle);
		dht_req_t item;
		item.kind   = kind;
		item.handle = handle;
		@(negedge clk);
		while ($urandom_range(99) < src_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req       <= item;
		// hold the item until the block takes it
		do @(posedge clk); while (req_stall !== 1'b0);
		sb.note_request(item);
	endtask

	initial begin
		int unsigned         n;
		int unsigned         pick;
		int unsigned         roll;
		logic [1:0]          kind;
		logic [HANDLE_W-1:0] h;
		sb        = new();
		arst_n    = 1'b0;
		req_valid = 1'b0;
		req       = '0;
		set_pace(0);
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// empty table, undefined kind, then a small table worked by hand
		send_item(KIND_LOOKUP, 32'd0);
		send_item(KIND_REMOVE, 32'd5);
		send_item(KIND_UNDEF, 32'hFFFF_FFFF);
		repeat (5) send_item(KIND_ADD, $urandom);
		send_item(KIND_LOOKUP, 32'd1);
		send_item(KIND_LOOKUP, 32'd5);
		send_item(KIND_LOOKUP, 32'hFFFF_FFFF);
		send_item(KIND_REMOVE, 32'd2);
		send_item(KIND_REMOVE, 32'd4);
		send_item(KIND_REMOVE, 32'd2);
		send_item(KIND_UNDEF, 32'd1);
		send_item(KIND_LOOKUP, 32'd5);
		send_item(KIND_REMOVE, 32'd1);
		send_item(KIND_REMOVE, 32'd3);
		send_item(KIND_REMOVE, 32'd5);
		send_item(KIND_ADD, 32'hFFFF_FFFF);

		for (int i = 0; i < 560; i++) begin
			if (i % 140 == 0)
				set_pace(i / 140);
			n    = sb.count;
			roll = $urandom_range(99);
			if (roll < ((n < 48) ? 40 : 15))
				kind = KIND_ADD;
			else if (roll < 70)
				kind = KIND_REMOVE;
			else if (roll < 95)
				kind = KIND_LOOKUP;
			else
				kind = KIND_UNDEF;
			pick = $urandom_range(99);
			if (kind != KIND_ADD && n > 0 && pick < 75)
				h = sb.ids[$urandom_range(n - 1)];
			else if (pick < 87)
				h = $urandom_range(sb.next_id);
			else if (pick < 95)
				h = $urandom;
			else
				h = pick[0] ? '1 : '0;
			send_item(kind, h);
		end

		@(negedge clk);
		req_valid <= 1'b0;
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (CAPACITY + 16) @(posedge clk);
		if (sb.errors == 0)
			$display("dense_handle_table_unit verification clean");
		else
			$display("dense_handle_table_unit verification failed");
		$finish;
	end

	initial begin
		#20ms;
		$display("dense_handle_table_unit verification failed");
		$finish;
	end

endmodule

[files.f]
rtl/core/dht_pkg.sv
rtl/core/dht_ctrl.sv
rtl/core/dht_dpath.sv
rtl/core/dense_handle_table_unit.sv
test/dense_handle_table_unit_tb.sv
